FILE: src/bbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the Bayer site lookup for the bilinear demosaic.
// Used by every module of the block; depends on nothing.
package bbd_pkg;

	localparam int PIX_W          = 8;
	localparam int LINE_WIDTH_W   = 12;
	localparam int ORDER_W        = 2;
	localparam int ROW_W          = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 12;
	localparam int MAX_WIDTH_DEF  = 2048;

	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST  = 12'd640;
	localparam logic [ORDER_W-1:0]      BAYER_ORDER_RST = 2'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAYER_ORDER = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		SITE_R  = 2'd0,
		SITE_GR = 2'd1,
		SITE_GB = 2'd2,
		SITE_B  = 2'd3
	} site_t;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel;
	} pix_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_last;
	} rgb_req_t;

	typedef struct packed {
		logic emit;
		logic mode_b;
		logic left_near;
		logic ox_odd;
		logic oy_odd;
		logic top_clamp;
		logic last;
	} item_t;

	function automatic site_t site_of(input logic [ORDER_W-1:0] order,
		input logic oy_odd, input logic ox_odd);
		site_t s;
		case ({order, oy_odd, ox_odd})
			4'b00_00: s = SITE_R;
			4'b00_01: s = SITE_GR;
			4'b00_10: s = SITE_GB;
			4'b00_11: s = SITE_B;
			4'b01_00: s = SITE_B;
			4'b01_01: s = SITE_GB;
			4'b01_10: s = SITE_GR;
			4'b01_11: s = SITE_R;
			4'b10_00: s = SITE_GR;
			4'b10_01: s = SITE_R;
			4'b10_10: s = SITE_B;
			4'b10_11: s = SITE_GB;
			4'b11_00: s = SITE_GB;
			4'b11_01: s = SITE_B;
			4'b11_10: s = SITE_R;
			4'b11_11: s = SITE_GR;
			default:  s = SITE_R;
		endcase
		return s;
	endfunction

endpackage

FILE: src/bbd_seq.sv
`timescale 1ns / 1ps
// Raster position tracking: column, row and drain counters, and per-request
// decode of line memory address and output selection. Depends on bbd_pkg.
module bbd_seq #(
	parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int WW = ($clog2(MAX_WIDTH + 1) > bbd_pkg::LINE_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : bbd_pkg::LINE_WIDTH_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                cmd,
	input  logic [bbd_pkg::LINE_WIDTH_W-1:0]    line_width,
	output logic                                enter,
	output logic [AW-1:0]                       addr,
	output bbd_pkg::item_t                      item
);

	localparam int DW = WW + 1;

	logic [AW-1:0]             col_q;
	logic [bbd_pkg::ROW_W-1:0] row_q;
	logic [DW-1:0]             drain_q;

	logic [WW-1:0] lw_ext;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] col_next_ext;
	logic [DW-1:0] drain_inc;
	logic          wrap;
	logic          last;
	logic          emit_a;
	logic          emit_b;

	always_comb begin
		lw_ext = WW'(line_width);
		if (lw_ext < WW'(2)) begin
			w_eff = WW'(2);
		end else if (lw_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = lw_ext;
		end
		col_next_ext = WW'(col_q) + WW'(1);
		wrap = col_next_ext >= w_eff;
		drain_inc = drain_q + DW'(1);
		last = (cmd == bbd_pkg::CMD_DRAIN) && (drain_inc >= (DW'(w_eff) + DW'(1)));
		enter = !((cmd == bbd_pkg::CMD_DRAIN) && (col_q == '0) && (row_q == '0));
		emit_a = (col_q == '0) && (row_q >= bbd_pkg::ROW_W'(2));
		emit_b = (col_q != '0) && (row_q >= bbd_pkg::ROW_W'(1));
		addr = col_q;
		item.emit = emit_a || emit_b;
		item.mode_b = emit_b;
		item.left_near = (col_q == AW'(1));
		item.ox_odd = emit_b ? ~col_q[0] : ~w_eff[0];
		item.oy_odd = emit_b ? ~row_q[0] : row_q[0];
		item.top_clamp = emit_b ? (row_q == bbd_pkg::ROW_W'(1)) :
			(row_q == bbd_pkg::ROW_W'(2));
		item.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			drain_q <= '0;
		end else if (accept && enter) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
				drain_q <= '0;
			end else begin
				drain_q <= (cmd == bbd_pkg::CMD_DRAIN) ? drain_inc : '0;
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + bbd_pkg::ROW_W'(1);
				end else begin
					col_q <= AW'(col_next_ext);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enter && last |=> (col_q == '0) && (row_q == '0) && (drain_q == '0))
		else $error("positions not cleared after the end of frame");
	a_ignored_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !enter |=> $stable(col_q) && $stable(row_q) && $stable(drain_q))
		else $error("drain outside a frame changed the positions");
`endif

endmodule

FILE: src/bbd_linebuf.sv
`timescale 1ns / 1ps
// Two line memories holding the previous two rows, with a registered read and
// forwarding of a write that lands on the entry being read. Depends on bbd_pkg.
module bbd_linebuf #(
	parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [bbd_pkg::PIX_W-1:0]  wr_up,
	input  logic [bbd_pkg::PIX_W-1:0]  wr_mid,
	output logic [bbd_pkg::PIX_W-1:0]  up,
	output logic [bbd_pkg::PIX_W-1:0]  mid
);

	logic [bbd_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [bbd_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [bbd_pkg::PIX_W-1:0] up_rd_q;
	logic [bbd_pkg::PIX_W-1:0] mid_rd_q;
	logic [bbd_pkg::PIX_W-1:0] fwd_up_q;
	logic [bbd_pkg::PIX_W-1:0] fwd_mid_q;
	logic                      hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= wr_up;
			middle_mem[wr_addr] <= wr_mid;
		end
		if (rd_en) begin
			up_rd_q <= upper_mem[rd_addr];
			mid_rd_q <= middle_mem[rd_addr];
		end
		if (wr_en) begin
			fwd_up_q <= wr_up;
			fwd_mid_q <= wr_mid;
		end
	end

	// A read issued in the same cycle as a write to the same entry would see old data, so the written value is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign up = hit_q ? fwd_up_q : up_rd_q;
	assign mid = hit_q ? fwd_mid_q : mid_rd_q;

`ifndef SYNTHESIS
	a_hit_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (wr_addr == rd_addr) |=> hit_q && (up == $past(wr_up))
			&& (mid == $past(wr_mid)))
		else $error("colliding write was not forwarded");
`endif

endmodule

FILE: src/bbd_interp.sv
`timescale 1ns / 1ps
// 3x3 window register and bilinear interpolation of one RGB pixel.
// Depends on bbd_pkg for the item decode and the Bayer site lookup.
module bbd_interp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  bbd_pkg::item_t                item,
	input  logic [bbd_pkg::ORDER_W-1:0]   order,
	input  logic [bbd_pkg::PIX_W-1:0]     up,
	input  logic [bbd_pkg::PIX_W-1:0]     mid,
	input  logic [bbd_pkg::PIX_W-1:0]     np,
	output logic [bbd_pkg::PIX_W-1:0]     red,
	output logic [bbd_pkg::PIX_W-1:0]     green,
	output logic [bbd_pkg::PIX_W-1:0]     blue
);

	typedef logic [2:0][bbd_pkg::PIX_W-1:0] column_t;

	column_t win_q [3];

	column_t new_col;
	column_t lcol;
	column_t ccol;
	column_t rcol;
	logic [bbd_pkg::PIX_W-1:0] l_top;
	logic [bbd_pkg::PIX_W-1:0] c_top;
	logic [bbd_pkg::PIX_W-1:0] r_top;
	logic [bbd_pkg::PIX_W+1:0] cross_sum;
	logic [bbd_pkg::PIX_W+1:0] diag_sum;
	logic [bbd_pkg::PIX_W:0]   horz_sum;
	logic [bbd_pkg::PIX_W:0]   vert_sum;
	logic [bbd_pkg::PIX_W-1:0] cross_avg;
	logic [bbd_pkg::PIX_W-1:0] diag;
	logic [bbd_pkg::PIX_W-1:0] horz;
	logic [bbd_pkg::PIX_W-1:0] vert;
	logic [bbd_pkg::PIX_W-1:0] ctr;
	bbd_pkg::site_t            site;

	always_comb begin
		new_col = {np, mid, up};
		lcol = (item.mode_b && item.left_near) ? win_q[2] : win_q[1];
		ccol = win_q[2];
		rcol = item.mode_b ? new_col : win_q[2];
		l_top = item.top_clamp ? lcol[1] : lcol[0];
		c_top = item.top_clamp ? ccol[1] : ccol[0];
		r_top = item.top_clamp ? rcol[1] : rcol[0];
		cross_sum = 10'(lcol[1]) + 10'(rcol[1]) + 10'(c_top) + 10'(ccol[2]) + 10'd2;
		diag_sum = 10'(l_top) + 10'(r_top) + 10'(lcol[2]) + 10'(rcol[2]) + 10'd2;
		horz_sum = 9'(lcol[1]) + 9'(rcol[1]) + 9'd1;
		vert_sum = 9'(c_top) + 9'(ccol[2]) + 9'd1;
		cross_avg = cross_sum[bbd_pkg::PIX_W+1:2];
		diag = diag_sum[bbd_pkg::PIX_W+1:2];
		horz = horz_sum[bbd_pkg::PIX_W:1];
		vert = vert_sum[bbd_pkg::PIX_W:1];
		ctr = ccol[1];
		site = bbd_pkg::site_of(order, item.oy_odd, item.ox_odd);
		case (site)
			bbd_pkg::SITE_R: begin
				red = ctr;
				green = cross_avg;
				blue = diag;
			end
			bbd_pkg::SITE_B: begin
				red = diag;
				green = cross_avg;
				blue = ctr;
			end
			bbd_pkg::SITE_GR: begin
				red = horz;
				green = ctr;
				blue = vert;
			end
			bbd_pkg::SITE_GB: begin
				red = vert;
				green = ctr;
				blue = horz;
			end
			default: begin
				red = ctr;
				green = ctr;
				blue = ctr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= new_col;
		end
	end

endmodule

FILE: src/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// Bilinear Bayer demosaic, top level. Takes one request per cycle unless the output stalls:
// the line memories are read at the accepting edge and the interpolation stage then
// registers the result, which raises rgb_valid. A result held at the output holds the
// interpolation stage, and a new request waits only while that stage is occupied.
// A pixel's result follows the request one line plus one pixel later in the stream.
// Asynchronous reset clears positions, window and handshakes, sets line_width to 640 and
// RGGB order; line memories are not cleared.
module bayer_bilinear_demosaic #(
	parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  bbd_pkg::pix_req_t                pix_req,
	output logic                             rgb_valid,
	input  logic                             rgb_ready,
	output bbd_pkg::rgb_req_t                rgb_req
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [bbd_pkg::LINE_WIDTH_W-1:0] line_width_q;
	logic [bbd_pkg::ORDER_W-1:0]      bayer_order_q;

	logic                      accept;
	logic                      enter;
	logic [AW-1:0]             rd_addr;
	bbd_pkg::item_t            item;

	logic                      valid_s1;
	bbd_pkg::item_t            item_s1;
	logic                      cmd_s1;
	logic [bbd_pkg::PIX_W-1:0] pix_s1;
	logic [AW-1:0]             addr_s1;
	logic                      fire_s1;

	logic [bbd_pkg::PIX_W-1:0] up;
	logic [bbd_pkg::PIX_W-1:0] mid;
	logic [bbd_pkg::PIX_W-1:0] np;
	logic [bbd_pkg::PIX_W-1:0] red;
	logic [bbd_pkg::PIX_W-1:0] green;
	logic [bbd_pkg::PIX_W-1:0] blue;

	logic                      rgb_valid_q;
	bbd_pkg::rgb_req_t         rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= bbd_pkg::LINE_WIDTH_RST;
			bayer_order_q <= bbd_pkg::BAYER_ORDER_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				bbd_pkg::CFG_LINE_WIDTH: begin
					line_width_q <= cfg_data[bbd_pkg::LINE_WIDTH_W-1:0];
				end
				bbd_pkg::CFG_BAYER_ORDER: begin
					bayer_order_q <= cfg_data[bbd_pkg::ORDER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign fire_s1 = valid_s1 && (!rgb_valid_q || rgb_ready);
	assign pix_ready = !valid_s1 || fire_s1;
	assign accept = pix_valid && pix_ready;

	bbd_seq #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(pix_req.cmd),
		.line_width(line_width_q),
		.enter(enter),
		.addr(rd_addr),
		.item(item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= accept && enter;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			cmd_s1 <= pix_req.cmd;
			pix_s1 <= pix_req.pixel;
			addr_s1 <= rd_addr;
		end
	end

	bbd_linebuf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_linebuf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept && enter),
		.rd_addr(rd_addr),
		.wr_en(fire_s1),
		.wr_addr(addr_s1),
		.wr_up(mid),
		.wr_mid(np),
		.up(up),
		.mid(mid)
	);

	assign np = (cmd_s1 == bbd_pkg::CMD_DRAIN) ? mid : pix_s1;

	bbd_interp u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.shift(fire_s1),
		.item(item_s1),
		.order(bayer_order_q),
		.up(up),
		.mid(mid),
		.np(np),
		.red(red),
		.green(green),
		.blue(blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rgb_valid_q <= item_s1.emit;
		end else if (rgb_ready) begin
			rgb_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rgb_q.red <= red;
			rgb_q.green <= green;
			rgb_q.blue <= blue;
			rgb_q.frame_last <= item_s1.last;
		end
	end

	assign rgb_valid = rgb_valid_q;
	assign rgb_req = rgb_q;

`ifndef SYNTHESIS
	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.emit |=> rgb_valid_q)
		else $error("interpolated pixel not presented");
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pix_ready)
		else $error("empty pipeline refused a request");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rgb_valid_q && !rgb_ready |=> valid_s1 && $stable(addr_s1))
		else $error("stalled request lost");
`endif

endmodule

FILE: verif/bayer_bilinear_demosaic_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear Bayer demosaic: streams raw Bayer frames,
// predicts every RGB result with its own line-buffer model and checks each one.
// Depends on bbd_pkg and the bayer_bilinear_demosaic top level.
module bayer_bilinear_demosaic_tb;

	localparam int MAXW          = bbd_pkg::MAX_WIDTH_DEF;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [bbd_pkg::ORDER_W-1:0] ORDER_RGGB = 2'd0;
	localparam logic [bbd_pkg::ORDER_W-1:0] ORDER_BGGR = 2'd1;
	localparam logic [bbd_pkg::ORDER_W-1:0] ORDER_GRBG = 2'd2;
	localparam logic [bbd_pkg::ORDER_W-1:0] ORDER_GBRG = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           pix_valid;
	logic                           pix_ready;
	bbd_pkg::pix_req_t              pix_req;
	logic                           rgb_valid;
	logic                           rgb_ready;
	bbd_pkg::rgb_req_t              rgb_req;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int stall_cycles;
	int requests_counted;

	logic [bbd_pkg::LINE_WIDTH_W-1:0] width_reg;
	logic [bbd_pkg::ORDER_W-1:0]      order_reg;
	bit [bbd_pkg::PIX_W-1:0]          upper_mem [MAXW];
	bit [bbd_pkg::PIX_W-1:0]          middle_mem [MAXW];
	bit                               middle_known [MAXW];
	bit [bbd_pkg::PIX_W-1:0]          win [9];
	int                               col_pos;
	int                               row_pos;
	int                               drain_cnt;
	bbd_pkg::rgb_req_t                rgb_expected [$];
	bbd_pkg::rgb_req_t                expected_px;

	bayer_bilinear_demosaic i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_req   (pix_req),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb_req   (rgb_req)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int active_width();
		int w;
		w = width_reg;
		if (w < 2) w = 2;
		if (w > MAXW) w = MAXW;
		return w;
	endfunction

	function automatic bbd_pkg::site_t site_at(input int ox, input int oy);
		logic red_row;
		logic red_col;
		case (order_reg)
			ORDER_RGGB: begin
				red_row = 1'b0;
				red_col = 1'b0;
			end
			ORDER_BGGR: begin
				red_row = 1'b1;
				red_col = 1'b1;
			end
			ORDER_GRBG: begin
				red_row = 1'b0;
				red_col = 1'b1;
			end
			default: begin
				red_row = 1'b1;
				red_col = 1'b0;
			end
		endcase
		if (oy[0] == red_row && ox[0] == red_col) return bbd_pkg::SITE_R;
		if (oy[0] != red_row && ox[0] != red_col) return bbd_pkg::SITE_B;
		return (oy[0] == red_row) ? bbd_pkg::SITE_GR : bbd_pkg::SITE_GB;
	endfunction

	function automatic bbd_pkg::rgb_req_t interpolate(input int lc, input int cc, input int rc,
		input int ox, input int oy, input logic is_last);
		int tr;
		int ctr;
		int cross_avg;
		int diag_avg;
		int horz_avg;
		int vert_avg;
		bbd_pkg::rgb_req_t px;
		tr = (oy == 0) ? 1 : 0;
		ctr = win[cc*3+1];
		cross_avg = (win[lc*3+1] + win[rc*3+1] + win[cc*3+tr] + win[cc*3+2] + 2) >> 2;
		diag_avg = (win[lc*3+tr] + win[rc*3+tr] + win[lc*3+2] + win[rc*3+2] + 2) >> 2;
		horz_avg = (win[lc*3+1] + win[rc*3+1] + 1) >> 1;
		vert_avg = (win[cc*3+tr] + win[cc*3+2] + 1) >> 1;
		case (site_at(ox, oy))
			bbd_pkg::SITE_R: begin
				px.red = ctr[bbd_pkg::PIX_W-1:0];
				px.green = cross_avg[bbd_pkg::PIX_W-1:0];
				px.blue = diag_avg[bbd_pkg::PIX_W-1:0];
			end
			bbd_pkg::SITE_B: begin
				px.blue = ctr[bbd_pkg::PIX_W-1:0];
				px.green = cross_avg[bbd_pkg::PIX_W-1:0];
				px.red = diag_avg[bbd_pkg::PIX_W-1:0];
			end
			bbd_pkg::SITE_GR: begin
				px.green = ctr[bbd_pkg::PIX_W-1:0];
				px.red = horz_avg[bbd_pkg::PIX_W-1:0];
				px.blue = vert_avg[bbd_pkg::PIX_W-1:0];
			end
			default: begin
				px.green = ctr[bbd_pkg::PIX_W-1:0];
				px.blue = horz_avg[bbd_pkg::PIX_W-1:0];
				px.red = vert_avg[bbd_pkg::PIX_W-1:0];
			end
		endcase
		px.frame_last = is_last;
		return px;
	endfunction

	task automatic predict_request(input logic cmd, input logic [bbd_pkg::PIX_W-1:0] pix);
		int w;
		int c;
		int r;
		int i;
		int k;
		bit [bbd_pkg::PIX_W-1:0] up;
		bit [bbd_pkg::PIX_W-1:0] mid;
		bit [bbd_pkg::PIX_W-1:0] np;
		logic is_last;
		bit got;
		bbd_pkg::rgb_req_t px;
		w = active_width();
		c = col_pos;
		r = row_pos;
		is_last = 1'b0;
		got = 1'b0;
		if (cmd == bbd_pkg::CMD_DRAIN && c == 0 && r == 0) return;
		requests_counted++;
		if (cmd == bbd_pkg::CMD_DRAIN) begin
			drain_cnt++;
			if (drain_cnt >= w + 1) is_last = 1'b1;
		end else begin
			drain_cnt = 0;
		end
		i = (c < MAXW) ? c : MAXW - 1;
		up = upper_mem[i];
		mid = middle_mem[i];
		np = (cmd == bbd_pkg::CMD_DRAIN) ? mid : pix;
		upper_mem[i] = mid;
		middle_mem[i] = np;
		middle_known[i] = 1'b1;
		if (c == 0 && r >= 2) begin
			px = interpolate(1, 2, 2, w - 1, r - 2, is_last);
			got = 1'b1;
		end
		for (k = 0; k < 6; k++) win[k] = win[k+3];
		win[6] = up;
		win[7] = mid;
		win[8] = np;
		if (c != 0 && r >= 1) begin
			px = interpolate((c == 1) ? 1 : 0, 1, 2, c - 1, r - 1, is_last);
			got = 1'b1;
		end
		if (got) rgb_expected.push_back(px);
		if (is_last) begin
			col_pos = 0;
			row_pos = 0;
			drain_cnt = 0;
		end else if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1) & 16'hFFFF;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// A drain copies the line above; it must never copy a line entry that was never written.
	function automatic bit drain_is_defined();
		if (col_pos == 0 && row_pos == 0) return 1'b1;
		return middle_known[(col_pos < MAXW) ? col_pos : MAXW - 1];
	endfunction

	task automatic send_request(input logic cmd, input logic [bbd_pkg::PIX_W-1:0] pix);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_req <= {cmd, pix};
		do @(posedge clk); while (!pix_ready);
		predict_request(cmd, pix);
	endtask

	task automatic wait_results_drained();
		pix_valid <= 1'b0;
		while (rgb_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [bbd_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[bbd_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		if (idx == bbd_pkg::CFG_LINE_WIDTH) width_reg = value[bbd_pkg::LINE_WIDTH_W-1:0];
		else order_reg = value[bbd_pkg::ORDER_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int width, input int order);
		wait_results_drained();
		if (width != width_reg) write_register(bbd_pkg::CFG_LINE_WIDTH, width);
		if (order != order_reg) write_register(bbd_pkg::CFG_BAYER_ORDER, order);
	endtask

	task automatic send_frame(input int rows, input int extra, input int drain_pct);
		int w;
		int target;
		int burst;
		w = active_width();
		target = rows * w + extra;
		while (row_pos * w + col_pos < target) begin
			if ($urandom_range(0, 99) < drain_pct && drain_is_defined()) begin
				burst = $urandom_range(1, 2);
				repeat (burst) begin
					if (drain_is_defined()) begin
						send_request(bbd_pkg::CMD_DRAIN,
							bbd_pkg::PIX_W'($urandom_range(0, 255)));
					end
				end
				send_request(bbd_pkg::CMD_PIXEL, bbd_pkg::PIX_W'($urandom_range(0, 255)));
			end else begin
				send_request(bbd_pkg::CMD_PIXEL, bbd_pkg::PIX_W'($urandom_range(0, 255)));
			end
		end
		while (col_pos != 0 || row_pos != 0) begin
			send_request(bbd_pkg::CMD_DRAIN, bbd_pkg::PIX_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic compare_field(input string name, input logic [bbd_pkg::PIX_W-1:0] want,
		input logic [bbd_pkg::PIX_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic test_edge_values();
		write_register(bbd_pkg::CFG_LINE_WIDTH, 0);
		write_register(bbd_pkg::CFG_BAYER_ORDER, int'(ORDER_RGGB));
		send_request(bbd_pkg::CMD_DRAIN, 8'hFF);
		send_request(bbd_pkg::CMD_PIXEL, 8'hFF);
		send_request(bbd_pkg::CMD_PIXEL, 8'h00);
		send_request(bbd_pkg::CMD_PIXEL, 8'h00);
		send_request(bbd_pkg::CMD_PIXEL, 8'hFF);
		send_request(bbd_pkg::CMD_PIXEL, 8'h01);
		send_request(bbd_pkg::CMD_PIXEL, 8'hFE);
		send_request(bbd_pkg::CMD_DRAIN, 8'h00);
		send_request(bbd_pkg::CMD_PIXEL, 8'h80);
		while (col_pos != 0 || row_pos != 0) send_request(bbd_pkg::CMD_DRAIN, 8'h55);
		wait_results_drained();
	endtask

	task automatic test_mosaic_orders();
		logic [bbd_pkg::ORDER_W-1:0] orders [4] = '{ORDER_RGGB, ORDER_BGGR, ORDER_GRBG,
			ORDER_GBRG};
		int widths [4] = '{1, 3, 5, 2};
		int n;
		for (n = 0; n < 4; n++) begin
			configure(widths[n], int'(orders[n]));
			send_frame(3, 0, 0);
		end
	endtask

	task automatic test_wide_rows();
		configure($urandom_range(100, 160), $urandom_range(ORDER_RGGB, ORDER_GBRG));
		send_frame(1, 0, 0);
	endtask

	task automatic test_random_frames(input int budget);
		int goal;
		int width;
		int rows;
		int extra;
		int pick;
		goal = requests_counted + budget;
		while (requests_counted < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) width = $urandom_range(0, 1);
				else if (pick == 1) width = $urandom_range(13, 64);
				else width = $urandom_range(2, 12);
				configure(width, $urandom_range(ORDER_RGGB, ORDER_GBRG));
			end
			rows = $urandom_range(1, 6);
			extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, active_width() - 1) : 0;
			send_frame(rows, extra, 5);
			if ($urandom_range(0, 4) == 0) begin
				send_request(bbd_pkg::CMD_DRAIN, bbd_pkg::PIX_W'($urandom_range(0, 255)));
			end
		end
	endtask

	always @(posedge clk) rgb_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && rgb_valid && rgb_ready) begin
			if (rgb_expected.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d frame_last %0d",
					rgb_req.red, rgb_req.green, rgb_req.blue, rgb_req.frame_last);
				fail_count++;
			end else begin
				expected_px = rgb_expected.pop_front();
				compare_field("red", expected_px.red, rgb_req.red);
				compare_field("green", expected_px.green, rgb_req.green);
				compare_field("blue", expected_px.blue, rgb_req.blue);
				compare_field("frame_last", bbd_pkg::PIX_W'(expected_px.frame_last),
					bbd_pkg::PIX_W'(rgb_req.frame_last));
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pix_valid = 1'b0;
		pix_req = '0;
		rgb_ready = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 67;
		fail_count = 0;
		stall_cycles = 0;
		requests_counted = 0;
		width_reg = bbd_pkg::LINE_WIDTH_RST;
		order_reg = bbd_pkg::BAYER_ORDER_RST;
		col_pos = 0;
		row_pos = 0;
		drain_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_values();
		test_mosaic_orders();
		test_random_frames(270);
		send_idle_pct = 67;
		recv_idle_pct = 11;
		test_wide_rows();
		test_random_frames(270);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(270);
		wait_results_drained();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
